// ----- rtl/core/led_bf_pkg.sv -----
// shared types and constants for the led blink and flash controller
`timescale 1ns / 1ps
`default_nettype none

package led_bf_pkg;

    localparam int NUM_LEDS   = 4;
    localparam int COUNT_BITS = 16;
    localparam int LEVEL_BITS = 4;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int LED_IDX_W  = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [CFG_BITS-1:0]   cfg_word_t;
    typedef logic [LED_IDX_W-1:0]  led_idx_t;

    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_BLINK   = 3'd2;
    localparam logic [2:0] MODE_FLASH   = 3'd3;
    localparam logic [2:0] MODE_LIMITED = 3'd4;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_SET     = 2'd1;
    localparam logic [1:0] REQ_TOGGLE  = 2'd2;
    localparam logic [1:0] REQ_LIMITED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITED_ON   = 3'd4;

    localparam cfg_word_t RST_BLINK_PERIOD = 16'd1000;
    localparam cfg_word_t RST_BLINK_ON     = 16'd500;
    localparam cfg_word_t RST_FLASH_PERIOD = 16'd1000;
    localparam cfg_word_t RST_FLASH_ON     = 16'd10;
    localparam cfg_word_t RST_LIMITED_ON   = 16'd10;

    typedef enum logic [2:0] {
        CMD_TICK,
        CMD_SET,
        CMD_TOGGLE,
        CMD_LIMITED,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        led_idx_t   idx;
        logic       idx_ok;
        logic [1:0] new_mode;
        cfg_word_t  flash_count;
        cfg_word_t  run_period;
    } cmd_t;

    typedef struct packed {
        cfg_word_t blink_period;
        cfg_word_t blink_on;
        cfg_word_t flash_period;
        cfg_word_t flash_on;
        cfg_word_t limited_on;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       level;
        cnt_t       cnt;
        cnt_t       cyc;
        cnt_t       lit;
        cnt_t       left;
    } led_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/led_blink_flash_controller.sv -----
// top level of the led blink and flash controller
//
// requests enter on in_valid/in_stall with req_type, led_index, new_mode,
// flash_count and run_period_ms; a request is taken when in_valid is high
// and in_stall is low. every request returns one result on
// out_valid/out_stall: led_levels (bit i lit) and addressed_mode.
// a two-entry queue sits between intake and execution, so requests keep
// arriving while a result waits for the receiver.
// set, toggle and limited run pass through the run and done states to the
// result register; a tick walks the led table one entry per cycle in run.
// execution takes one command at a time: the next leaves the queue only
// when the result of the last is loaded in the done state.
// while out_stall is high the result register holds, execution waits and
// the queue fills; in_stall rises when the queue is full.
// the cfg_we/cfg_index/cfg_data port writes the five timing registers;
// write them only while the block is idle.
// reset clears every led to off with zeroed counters and loads the timing
// registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_flash_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [1:0]  led_index,
    input  wire logic [1:0]  new_mode,
    input  wire logic [15:0] flash_count,
    input  wire logic [15:0] run_period_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       led_levels,
    output logic [2:0]       addressed_mode
);

    led_bf_pkg::cfg_t cfg_reg;
    led_bf_pkg::cmd_t cmd;
    logic             cmd_valid;
    logic             cmd_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blink_period <= led_bf_pkg::RST_BLINK_PERIOD;
            cfg_reg.blink_on     <= led_bf_pkg::RST_BLINK_ON;
            cfg_reg.flash_period <= led_bf_pkg::RST_FLASH_PERIOD;
            cfg_reg.flash_on     <= led_bf_pkg::RST_FLASH_ON;
            cfg_reg.limited_on   <= led_bf_pkg::RST_LIMITED_ON;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                led_bf_pkg::CFG_BLINK_PERIOD: cfg_reg.blink_period <= cfg_data;
                led_bf_pkg::CFG_BLINK_ON:     cfg_reg.blink_on     <= cfg_data;
                led_bf_pkg::CFG_FLASH_PERIOD: cfg_reg.flash_period <= cfg_data;
                led_bf_pkg::CFG_FLASH_ON:     cfg_reg.flash_on     <= cfg_data;
                led_bf_pkg::CFG_LIMITED_ON:   cfg_reg.limited_on   <= cfg_data;
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    led_bf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .led_index     (led_index),
        .new_mode      (new_mode),
        .flash_count   (flash_count),
        .run_period_ms (run_period_ms),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    led_bf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .led_levels     (led_levels),
        .addressed_mode (addressed_mode)
    );

endmodule

`default_nettype wire

// ----- rtl/core/led_bf_front.sv -----
// request intake: classification and a short command queue
`timescale 1ns / 1ps
`default_nettype none

module led_bf_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [1:0]                  req_type,
    input  wire logic [1:0]                  led_index,
    input  wire logic [1:0]                  new_mode,
    input  wire logic [15:0]                 flash_count,
    input  wire logic [15:0]                 run_period_ms,
    output logic                             cmd_valid,
    output led_bf_pkg::cmd_t                 cmd,
    input  wire logic                        cmd_pop
);

    led_bf_pkg::cmd_t                     queue_reg [led_bf_pkg::QDEPTH];
    logic [led_bf_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [led_bf_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [led_bf_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [led_bf_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [led_bf_pkg::QCNT_W-1:0]        count_reg;
    logic [led_bf_pkg::QCNT_W-1:0]        count_next;
    led_bf_pkg::cmd_t                     cmd_in;
    logic                                 push;

    // classify the request
    always_comb
    begin
        cmd_in.idx         = led_bf_pkg::led_idx_t'(led_index);
        cmd_in.idx_ok      = 32'(led_index) < 32'(led_bf_pkg::NUM_LEDS);
        cmd_in.new_mode    = new_mode;
        cmd_in.flash_count = flash_count;
        cmd_in.run_period  = run_period_ms;
        case (req_type)
            led_bf_pkg::REQ_TICK:    cmd_in.kind = led_bf_pkg::CMD_TICK;
            led_bf_pkg::REQ_SET:     cmd_in.kind = led_bf_pkg::CMD_SET;
            led_bf_pkg::REQ_TOGGLE:  cmd_in.kind = led_bf_pkg::CMD_TOGGLE;
            led_bf_pkg::REQ_LIMITED: cmd_in.kind = led_bf_pkg::CMD_LIMITED;
            default:                 cmd_in.kind = led_bf_pkg::CMD_NOP;
        endcase
        if (!cmd_in.idx_ok && (req_type != led_bf_pkg::REQ_TICK))
        begin
            cmd_in.kind = led_bf_pkg::CMD_NOP;
        end
    end

    assign in_stall  = (count_reg == led_bf_pkg::QCNT_W'(led_bf_pkg::QDEPTH));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (count_reg != '0))
        else $error("command popped from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= led_bf_pkg::QCNT_W'(led_bf_pkg::QDEPTH))
        else $error("queue count out of range");

    a_stall_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> cmd_valid)
        else $error("input stalled with an empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/led_bf_back.sv -----
// command execution: led table, tick sweep and result register
`timescale 1ns / 1ps
`default_nettype none

module led_bf_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire led_bf_pkg::cfg_t            cfg,
    input  wire logic                        cmd_valid,
    input  wire led_bf_pkg::cmd_t            cmd,
    output logic                             cmd_pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [3:0]                       led_levels,
    output logic [2:0]                       addressed_mode
);

    led_bf_pkg::back_state_t state_reg;
    led_bf_pkg::back_state_t state_next;
    led_bf_pkg::cmd_t        cur_reg;
    led_bf_pkg::led_idx_t    sweep_idx_reg;
    led_bf_pkg::led_idx_t    sweep_idx_next;
    led_bf_pkg::led_entry_t  entry_reg [led_bf_pkg::NUM_LEDS];
    led_bf_pkg::led_entry_t  rd_entry;
    led_bf_pkg::led_entry_t  wr_entry;
    led_bf_pkg::led_idx_t    addr;
    logic                    entry_we;
    logic                    load_out;
    logic                    out_free;
    logic                    sweep_last;
    logic [2:0]              set_mode_val;
    logic                    out_valid_reg;
    logic [3:0]              led_levels_reg;
    logic [2:0]              addressed_mode_reg;
    logic [3:0]              levels;

    assign out_free   = !out_valid_reg || !out_stall;
    assign sweep_last = (sweep_idx_reg ==
                         led_bf_pkg::led_idx_t'(led_bf_pkg::NUM_LEDS - 1));
    assign addr       = ((state_reg == led_bf_pkg::S_RUN) &&
                         (cur_reg.kind == led_bf_pkg::CMD_TICK)) ?
                        sweep_idx_reg : cur_reg.idx;
    assign rd_entry   = entry_reg[addr];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            led_bf_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = led_bf_pkg::S_RUN;
                end
            end
            led_bf_pkg::S_RUN:
            begin
                if ((cur_reg.kind != led_bf_pkg::CMD_TICK) || sweep_last)
                begin
                    state_next = led_bf_pkg::S_DONE;
                end
            end
            led_bf_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = cmd_valid ? led_bf_pkg::S_RUN : led_bf_pkg::S_IDLE;
                end
            end
            default: state_next = led_bf_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        entry_we = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            led_bf_pkg::S_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            led_bf_pkg::S_RUN:
            begin
                entry_we = (cur_reg.kind != led_bf_pkg::CMD_NOP);
            end
            led_bf_pkg::S_DONE:
            begin
                load_out = out_free;
                cmd_pop  = out_free && cmd_valid;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // entry update
    always_comb
    begin
        wr_entry     = rd_entry;
        set_mode_val = {1'b0, cur_reg.new_mode};
        if (cur_reg.kind == led_bf_pkg::CMD_TOGGLE)
        begin
            set_mode_val = (rd_entry.mode == led_bf_pkg::MODE_OFF) ?
                           led_bf_pkg::MODE_ON : led_bf_pkg::MODE_OFF;
        end
        case (cur_reg.kind)
            led_bf_pkg::CMD_TICK:
            begin
                if ((rd_entry.mode == led_bf_pkg::MODE_BLINK) ||
                    (rd_entry.mode == led_bf_pkg::MODE_FLASH) ||
                    (rd_entry.mode == led_bf_pkg::MODE_LIMITED))
                begin
                    if (rd_entry.cnt >= rd_entry.cyc)
                    begin
                        wr_entry.cnt = '0;
                        if (rd_entry.mode == led_bf_pkg::MODE_LIMITED)
                        begin
                            if (rd_entry.left != '0)
                            begin
                                wr_entry.left  = rd_entry.left - 1'b1;
                                wr_entry.level = 1'b1;
                            end
                        end
                        else
                        begin
                            wr_entry.level = 1'b1;
                        end
                    end
                    else
                    begin
                        if (rd_entry.cnt == rd_entry.lit)
                        begin
                            wr_entry.level = 1'b0;
                        end
                        wr_entry.cnt = rd_entry.cnt + 1'b1;
                    end
                end
            end
            led_bf_pkg::CMD_SET, led_bf_pkg::CMD_TOGGLE:
            begin
                wr_entry.mode = set_mode_val;
                wr_entry.cnt  = '0;
                wr_entry.cyc  = '0;
                wr_entry.left = '0;
                case (set_mode_val)
                    led_bf_pkg::MODE_ON:
                    begin
                        wr_entry.level = 1'b1;
                    end
                    led_bf_pkg::MODE_BLINK:
                    begin
                        wr_entry.cyc   = led_bf_pkg::cnt_t'(cfg.blink_period);
                        wr_entry.lit   = led_bf_pkg::cnt_t'(cfg.blink_on);
                        wr_entry.level = 1'b1;
                    end
                    led_bf_pkg::MODE_FLASH:
                    begin
                        wr_entry.cyc   = led_bf_pkg::cnt_t'(cfg.flash_period);
                        wr_entry.lit   = led_bf_pkg::cnt_t'(cfg.flash_on);
                        wr_entry.level = 1'b1;
                    end
                    default:
                    begin
                        wr_entry.level = 1'b0;
                    end
                endcase
            end
            led_bf_pkg::CMD_LIMITED:
            begin
                wr_entry.mode = led_bf_pkg::MODE_LIMITED;
                wr_entry.cnt  = '0;
                wr_entry.cyc  = led_bf_pkg::cnt_t'(cur_reg.run_period);
                wr_entry.lit  = led_bf_pkg::cnt_t'(cfg.limited_on);
                if (cur_reg.flash_count != '0)
                begin
                    wr_entry.level = 1'b1;
                    wr_entry.left  = led_bf_pkg::cnt_t'(cur_reg.flash_count - 1'b1);
                end
                else
                begin
                    wr_entry.left = '0;
                end
            end
            default:
            begin
                wr_entry = rd_entry;
            end
        endcase
    end

    always_comb
    begin
        sweep_idx_next = sweep_idx_reg;
        if ((state_reg == led_bf_pkg::S_RUN) && (cur_reg.kind == led_bf_pkg::CMD_TICK))
        begin
            sweep_idx_next = sweep_last ? '0 : sweep_idx_reg + 1'b1;
        end
    end

    // low leds onto the level bus
    for (genvar k = 0; k < led_bf_pkg::LEVEL_BITS; k++)
    begin : g_levels
        if (k < led_bf_pkg::NUM_LEDS)
        begin : g_led
            assign levels[k] = entry_reg[k].level;
        end
        else
        begin : g_none
            assign levels[k] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= led_bf_pkg::S_IDLE;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < led_bf_pkg::NUM_LEDS; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            sweep_idx_reg <= sweep_idx_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (entry_we)
            begin
                entry_reg[addr] <= wr_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg <= cmd;
        end
        if (load_out)
        begin
            led_levels_reg     <= levels;
            addressed_mode_reg <= cur_reg.idx_ok ? rd_entry.mode : led_bf_pkg::MODE_OFF;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_levels     = led_levels_reg;
    assign addressed_mode = addressed_mode_reg;

`ifndef SYNTHESIS
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> ((state_reg == led_bf_pkg::S_IDLE) || (state_reg == led_bf_pkg::S_DONE)))
        else $error("command taken while another is executing");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !entry_we && (state_reg == led_bf_pkg::S_DONE))
        else $error("result loaded outside completion");

    a_sweep_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != led_bf_pkg::S_RUN) |-> (sweep_idx_reg == '0))
        else $error("sweep index left nonzero");
`endif

endmodule

`default_nettype wire
